>>> rtl/imu_sample_interpolator_defines.svh
// Assertion macros for the IMU sample interpolator
`ifndef IMU_SAMPLE_INTERPOLATOR_DEFINES_SVH
`define IMU_SAMPLE_INTERPOLATOR_DEFINES_SVH

// Implication checked at every clock edge outside reset
`define IMU_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Implication checked in the cycle after the trigger
`define IMU_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

>>> rtl/imu_si_pkg.sv
// Package: types and constants of the IMU sample interpolator
`timescale 1ns / 1ps
package imu_si_pkg;
   localparam int ChanCount   = 10;
   localparam int MotionCount = 6;
   localparam int StampWidth  = 48;
   localparam int WordWidth   = 32;

   localparam logic CfgMinSamples = 1'b0;
   localparam logic CfgEdgeLimit  = 1'b1;

   // Operation codes for the shared divide / root unit
   typedef enum logic [1:0] {
      OP_DIV  = 2'b01,
      OP_ROOT = 2'b10
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
      logic [63:0] num;
      logic [33:0] den;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;
endpackage

>>> rtl/imu_sample_interpolator.sv
// Top level of the IMU sample interpolator: queue, sequencer and result register
//
// Channel | Ports       | Beat contents
// --------+-------------+----------------------------------------------------
// input   | req_t*      | tuser func; tdata stamp, acc xyz, rate xyz, quat xyzw
// result  | rsp_t*      | tuser sync_ok; tdata stamp, acc, rate, quat
// config  | csr_*       | index 0 min_samples, index 1 edge_limit
//
// A push is the accepting cycle, then ten word writes. A sync discards stale
// samples one at a time, then divides for the weight (skipped on equal stamps),
// blends each motion and quaternion word, takes a root and runs four divisions;
// the divisions and the root go through the shared bit-serial divide/root unit.
// Reset is synchronous and empties the queue. req_tready is low while an item
// is in work or a result waits.
`timescale 1ns / 1ps
`include "imu_sample_interpolator_defines.svh"
module imu_sample_interpolator
   import imu_si_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [0:0]   req_tuser,   // func
   // stamp[47:0], acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, quat_x..quat_w
   input  logic [367:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [0:0]   rsp_tuser,   // sync_ok
   // out_stamp[47:0], out_acc_x..z, out_rate_x..z, out_quat_x..w
   output logic [367:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam int MemW = $clog2(QUEUE_DEPTH * ChanCount);

   typedef enum logic [14:0] {
      ST_IDLE  = 15'b000000000000001,
      ST_PUSH  = 15'b000000000000010,
      ST_CHK0  = 15'b000000000000100,
      ST_CHK1  = 15'b000000000001000,
      ST_WDIV  = 15'b000000000010000,
      ST_WWAIT = 15'b000000000100000,
      ST_RDF   = 15'b000000001000000,
      ST_RDS   = 15'b000000010000000,
      ST_MUL   = 15'b000000100000000,
      ST_ROOT  = 15'b000001000000000,
      ST_RWAIT = 15'b000010000000000,
      ST_NDIV  = 15'b000100000000000,
      ST_NWAIT = 15'b001000000000000,
      ST_OUT   = 15'b010000000000000,
      ST_SQ    = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   // sample memory: stamps and ten data words per slot
   logic [StampWidth-1:0] stamp_mem [QUEUE_DEPTH];
   logic [WordWidth-1:0]  data_mem  [QUEUE_DEPTH*ChanCount];
   logic [StampWidth-1:0] t0_ff, t1_ff;
   logic [WordWidth-1:0]  rd_ff;

   logic [IdxW-1:0] head_ff, head_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [4:0]      min_ff;
   logic [31:0]     edge_ff;

   logic [367:0]    item_ff, item_in;
   logic [3:0]      ch_ff, ch_in;
   logic [31:0]     w_ff, w_in;
   logic [31:0]     f_ff, f_in;
   logic [63:0]     prod_ff, prod_in;
   logic            phase_ff, phase_in;
   logic [31:0]     res_ff [ChanCount];
   logic [31:0]     res_in [ChanCount];
   logic [63:0]     sumsq_ff, sumsq_in;
   logic [32:0]     root_ff, root_in;
   logic            ok_ff, ok_in;
   logic            out_v_ff, out_v_in;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   imu_si_alu u_alu (.clock(clock), .reset(reset), .req(alu_req), .rsp(alu_rsp));

   logic [CntW-1:0] need;
   logic [IdxW-1:0] slot1, wslot;
   logic [31:0]     wsum;
   logic [MemW-1:0] rd_addr, wr_addr;
   logic            wr_en;
   logic [StampWidth-1:0] target;
   logic [48:0] dif_b, dif_a;
   logic [31:0] mag;
   logic [63:0] qmag;
   logic [33:0] mag_sat;
   // the one multiplier, shared by both blend products and the squares
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [64:0] blend_sum;

   assign target = item_ff[47:0];
   assign slot1  = (32'(head_ff) == QUEUE_DEPTH - 1) ? '0 : head_ff + IdxW'(1);
   assign wsum   = 32'(head_ff) + 32'(count_ff);
   assign wslot  = IdxW'((wsum >= QUEUE_DEPTH) ? wsum - QUEUE_DEPTH : wsum);
   assign need   = (min_ff < 5'd2) ? CntW'(2) :
                   ((32'(min_ff) > QUEUE_DEPTH) ? CntW'(QUEUE_DEPTH + 1) : CntW'(min_ff));
   assign dif_b  = {1'b0, target} - {1'b0, t0_ff};
   assign dif_a  = {1'b0, t1_ff} - {1'b0, target};
   assign mag    = res_ff[ch_ff][31] ? (32'd0 - res_ff[ch_ff]) : res_ff[ch_ff];
   assign qmag   = (alu_rsp.result + 64'd1) >> 1;
   assign mul_p  = mul_a * mul_b;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      item_in   = item_ff;
      ch_in     = ch_ff;
      w_in      = w_ff;
      f_in      = f_ff;
      prod_in   = prod_ff;
      phase_in  = phase_ff;
      res_in    = res_ff;
      sumsq_in  = sumsq_ff;
      root_in   = root_ff;
      ok_in     = ok_ff;
      out_v_in  = out_v_ff;
      alu_req   = '{start: 1'b0, op: OP_DIV, num: '0, den: '0};
      rd_addr   = '0;
      wr_addr   = '0;
      wr_en     = 1'b0;
      mag_sat   = '0;
      mul_a     = '0;
      mul_b     = '0;
      blend_sum = '0;
      if (out_v_ff && rsp_tready) out_v_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !out_v_ff) begin
               item_in = req_tdata;
               ch_in   = '0;
               if (!req_tuser[0]) begin
                  if (32'(count_ff) >= QUEUE_DEPTH) begin
                     head_in  = slot1;
                     count_in = count_ff - CntW'(1);
                  end
                  state_in = ST_PUSH;
               end else begin
                  for (int k = 0; k < ChanCount; k++) res_in[k] = '0;
                  ok_in    = 1'b0;
                  state_in = ST_CHK0;
               end
            end
         end
         ST_PUSH: begin
            wr_en   = 1'b1;
            wr_addr = MemW'(32'(wslot) * ChanCount + 32'(ch_ff));
            ch_in   = ch_ff + 4'd1;
            if (32'(ch_ff) == ChanCount - 1) begin
               count_in = count_ff + CntW'(1);
               state_in = ST_IDLE;
            end
         end
         ST_CHK0: begin
            // stamps t0/t1 load this cycle
            if (count_ff < need) state_in = ST_OUT;
            else state_in = ST_CHK1;
         end
         ST_CHK1: begin
            if (t0_ff > target) state_in = ST_OUT;
            else if (t1_ff < target) begin
               head_in  = slot1;
               count_in = count_ff - CntW'(1);
               state_in = ST_CHK0;
            end else if (dif_b[47:0] > {16'd0, edge_ff} || dif_a[47:0] > {16'd0, edge_ff}) begin
               head_in  = slot1;
               count_in = count_ff - CntW'(1);
               state_in = ST_OUT;
            end else begin
               w_in   = '0;
               if (t1_ff != t0_ff) begin
                  alu_req = '{start: 1'b1, op: OP_DIV, num: {dif_b[32:0], 31'd0},
                              den: 34'(t1_ff - t0_ff)};
                  state_in = ST_WWAIT;
               end else state_in = ST_RDF;
               ch_in = '0;
            end
         end
         ST_WWAIT: begin
            if (alu_rsp.done) begin
               w_in     = 32'(qmag);
               state_in = ST_RDF;
            end
         end
         ST_RDF: begin
            rd_addr  = MemW'(32'(head_ff) * ChanCount + 32'(ch_ff));
            phase_in = 1'b0;
            state_in = ST_RDS;
         end
         ST_RDS: begin
            f_in     = rd_ff;
            rd_addr  = MemW'(32'(slot1) * ChanCount + 32'(ch_ff));
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // two products through one multiplier, then the rounded sum
            if (!phase_ff) begin
               mul_a    = {f_ff[31], f_ff};
               mul_b    = {1'b0, 32'h4000_0000 - w_ff};
               prod_in  = mul_p[63:0];
               f_in     = rd_ff;
               phase_in = 1'b1;
            end else begin
               mul_a     = {f_ff[31], f_ff};
               mul_b     = {1'b0, w_ff};
               blend_sum = {prod_ff[63], prod_ff} + mul_p[64:0] + 65'h0_2000_0000;
               res_in[ch_ff] = blend_sum[61:30];
               if (32'(ch_ff) >= MotionCount) state_in = ST_SQ;
               else begin
                  ch_in    = ch_ff + 4'd1;
                  state_in = ST_RDF;
               end
            end
         end
         ST_SQ: begin
            mul_a    = {res_ff[ch_ff][31], res_ff[ch_ff]};
            mul_b    = {res_ff[ch_ff][31], res_ff[ch_ff]};
            sumsq_in = sumsq_ff + (mul_p[63:0] >> 2);
            if (32'(ch_ff) == ChanCount - 1) state_in = ST_ROOT;
            else begin
               ch_in    = ch_ff + 4'd1;
               state_in = ST_RDF;
            end
         end
         ST_ROOT: begin
            alu_req  = '{start: 1'b1, op: OP_ROOT, num: sumsq_ff, den: '0};
            state_in = ST_RWAIT;
         end
         ST_RWAIT: begin
            if (alu_rsp.done) begin
               root_in = 33'(alu_rsp.result);
               ch_in   = 4'(MotionCount);
               if (alu_rsp.result == 64'd0) begin
                  ok_in    = 1'b1;
                  state_in = ST_OUT;
               end else state_in = ST_NDIV;
            end
         end
         ST_NDIV: begin
            alu_req  = '{start: 1'b1, op: OP_DIV, num: {2'b00, mag, 30'd0},
                         den: {1'b0, root_ff}};
            state_in = ST_NWAIT;
         end
         ST_NWAIT: begin
            if (alu_rsp.done) begin
               mag_sat = (qmag > 64'h8000_0000) ? 34'h0_8000_0000 : 34'(qmag);
               if (res_ff[ch_ff][31]) res_in[ch_ff] = 32'(34'd0 - mag_sat);
               else res_in[ch_ff] = (mag_sat > 34'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_sat[31:0];
               if (32'(ch_ff) == ChanCount - 1) begin
                  ok_in    = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  ch_in    = ch_ff + 4'd1;
                  state_in = ST_NDIV;
               end
            end
         end
         ST_OUT: begin
            out_v_in = 1'b1;
            sumsq_in = '0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_CHK1 && state_in == ST_RDF) sumsq_in = '0;
      if (state_ff == ST_WWAIT && state_in == ST_RDF) sumsq_in = '0;
   end

   // memories: written and read in one clocked block
   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_mem[wr_addr] <= item_ff[48 + 32*ch_ff +: 32];
         if (ch_ff == 4'd0) stamp_mem[wslot] <= item_ff[47:0];
      end
      rd_ff <= data_mem[rd_addr];
      t0_ff <= stamp_mem[head_ff];
      t1_ff <= stamp_mem[slot1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         min_ff   <= 5'd2;
         edge_ff  <= 32'd20000;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         out_v_ff <= out_v_in;
         if (csr_we && csr_index == CfgMinSamples) min_ff <= csr_wdata[4:0];
         if (csr_we && csr_index == CfgEdgeLimit) edge_ff <= csr_wdata;
      end
      item_ff  <= item_in;
      ch_ff    <= ch_in;
      w_ff     <= w_in;
      f_ff     <= f_in;
      prod_ff  <= prod_in;
      phase_ff <= phase_in;
      res_ff   <= res_in;
      sumsq_ff <= sumsq_in;
      root_ff  <= root_in;
      ok_ff    <= ok_in;
   end

   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = ok_ff;
   always_comb begin
      rsp_tdata = '0;
      if (ok_ff) begin
         rsp_tdata[47:0] = item_ff[47:0];
         for (int k = 0; k < ChanCount; k++) rsp_tdata[48 + 32*k +: 32] = res_ff[k];
      end
   end

   `IMU_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= QUEUE_DEPTH, "queue overfull")
   `IMU_ASSERT_IMP(a_ready_idle, clock, reset, req_tready, state_ff == ST_IDLE, "ready outside idle")
   `IMU_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result lost")
endmodule

>>> rtl/imu_si_alu.sv
// Shared bit-serial divider and square root unit
`timescale 1ns / 1ps
module imu_si_alu
   import imu_si_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type req,
   output alu_rsp_type rsp
);
   logic [63:0] num_ff, num_in;
   logic [33:0] den_ff, den_in;
   logic [65:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   alu_op_type  op_ff, op_in;
   logic [65:0] trial;
   logic [65:0] rem_sh;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      op_in   = op_ff;
      done_in = 1'b0;
      rem_sh  = '0;
      trial   = '0;
      if (req.start) begin
         num_in  = req.num;
         den_in  = req.den;
         op_in   = req.op;
         rem_in  = '0;
         quo_in  = '0;
         busy_in = 1'b1;
         cnt_in  = (req.op == OP_DIV) ? 7'd64 : 7'd32;
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            // restoring division, one quotient bit per cycle
            rem_sh = {rem_ff[64:0], num_ff[63]};
            trial  = rem_sh - {32'd0, den_ff};
            num_in = {num_ff[62:0], 1'b0};
            if (!trial[65]) begin
               rem_in = trial;
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[62:0], 1'b0};
            end
         end else begin
            // digit-by-digit root, two radicand bits per cycle
            rem_sh = {rem_ff[63:0], num_ff[63:62]};
            trial  = rem_sh - {quo_ff[63:0], 2'b01};
            num_in = {num_ff[61:0], 2'b00};
            if (!trial[65]) begin
               rem_in = trial;
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[62:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= OP_DIV;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = quo_ff;
endmodule
